[rtl/core/cdq_pkg.sv]
// Package for the circular deque ring: action and status codes, widths.
// No dependencies; imported by circular_deque_ring.
`default_nettype none
package cdq_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_REAR  = 3'd0,
    ACT_POP_FRONT  = 3'd1,
    ACT_LIST       = 3'd2,
    ACT_PUSH_FRONT = 3'd3,
    ACT_POP_REAR   = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

endpackage
`default_nettype wire

[rtl/core/circular_deque_ring.sv]
// Double-ended queue on a ring of DEPTH signed words held in one memory.
// Uses cdq_pkg for action and status codes and widths.
//
// Push and pop items each give one result item. A list item of n stored entries
// gives n results (one EMPTY result for an empty ring): taking it starts the
// read at the front, then the entries come from the single registered read port
// of the ring memory, one per cycle unless the far side stalls, and no new item
// is taken until the last entry of the listing is loaded into the output
// register. An item is also held off while the output register keeps a result
// that the far side stalls. Action codes 5 to 7 are taken and give no result.
// Pops return no value; entry_value is zero on all results but listed entries.
`default_nettype none
module circular_deque_ring #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [cdq_pkg::ACTION_W-1:0]        in_action,
  input  wire logic signed [cdq_pkg::VALUE_W-1:0]  in_push_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [cdq_pkg::STATUS_W-1:0]             out_status,
  output logic signed [cdq_pkg::VALUE_W-1:0]       out_entry_value,
  output logic                                     out_last
);
  import cdq_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic {S_IDLE, S_LIST} state_t;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - IDX_W'(1);
  endfunction

  logic signed [VALUE_W-1:0] ring_mem [DEPTH];
  logic signed [VALUE_W-1:0] rdata_r;

  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          front_r, front_nxt;
  logic [IDX_W-1:0]          rear_r, rear_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          list_idx_r, list_idx_nxt;
  logic [CNT_W-1:0]          left_r, left_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      out_free;
  logic                      accept;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    count_nxt      = count_r;
    list_idx_nxt   = list_idx_r;
    left_nxt       = left_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    if (accept) begin
      case (in_action)
        ACT_PUSH_REAR, ACT_PUSH_FRONT: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          if (count_r == CNT_FULL) begin
            out_status_nxt = ST_OVERFLOW;
          end else begin
            out_status_nxt = ST_DONE;
            wr_en          = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
            if (count_r == '0) begin
              front_nxt = '0;
              rear_nxt  = '0;
              wr_addr   = '0;
            end else if (in_action == ACT_PUSH_REAR) begin
              rear_nxt = idx_next(rear_r);
              wr_addr  = idx_next(rear_r);
            end else begin
              front_nxt = idx_prev(front_r);
              wr_addr   = idx_prev(front_r);
            end
          end
        end
        ACT_POP_FRONT, ACT_POP_REAR: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          if (count_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_status_nxt = ST_DONE;
            count_nxt      = count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              front_nxt = '0;
              rear_nxt  = '0;
            end else if (in_action == ACT_POP_FRONT) begin
              front_nxt = idx_next(front_r);
            end else begin
              rear_nxt = idx_prev(rear_r);
            end
          end
        end
        ACT_LIST: begin
          if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
            out_value_nxt  = '0;
            out_last_nxt   = 1'b1;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = front_r;
            list_idx_nxt = idx_next(front_r);
            left_nxt     = count_r;
            state_nxt    = S_LIST;
          end
        end
        default: begin
        end
      endcase
    end

    if ((state_r == S_LIST) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_DONE;
      out_value_nxt  = rdata_r;
      out_last_nxt   = (left_r == CNT_W'(1));
      left_nxt       = left_r - CNT_W'(1);
      if (left_r == CNT_W'(1)) begin
        state_nxt = S_IDLE;
      end else begin
        rd_en        = 1'b1;
        rd_addr      = list_idx_r;
        list_idx_nxt = idx_next(list_idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= in_push_value;
    end
    if (rd_en) begin
      rdata_r <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      count_r     <= '0;
      list_idx_r  <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      count_r     <= count_nxt;
      list_idx_r  <= list_idx_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_value_r;
  assign out_last        = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("occupancy above ring depth");

  a_list_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (left_r != '0) && (left_r <= count_r))
    else $error("listing count out of range");

  a_no_accept_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> in_stall)
    else $error("item taken during listing");

  a_status_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_DONE)) |-> (out_value_r == '0) && out_last_r)
    else $error("status result carries a value or is not last");

  a_empty_indices: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (front_r == '0) && (rear_r == '0))
    else $error("empty ring with nonzero indices");

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for circular_deque_ring: directed table plus biased random actions,
// every result checked against a behavioral deque mirror. Uses cdq_pkg.
module tb_top;
  import cdq_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int RESET_CYCLES = 10;
  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM = 170;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 3 * DEPTH;
  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

  typedef struct packed {
    status_t status;
    logic signed [VALUE_W-1:0] entry;
    logic last;
  } ring_result_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0] value;
    logic typed;
    status_t want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{ACT_LIST,       32'h0000_0000, 1'b1, ST_EMPTY},
    '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY},
    '{ACT_POP_REAR,   32'h7FFF_FFFF, 1'b1, ST_EMPTY},
    '{ACT_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, ST_DONE},
    '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, ST_DONE},
    '{ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_DONE},
    '{ACT_LIST,       32'hFFFF_FFFF, 1'b0, ST_DONE},
    '{ACT_POP_REAR,   32'h0000_0000, 1'b1, ST_DONE},
    '{ACT_UNUSED_LO,  32'hFFFF_FFFF, 1'b0, ST_DONE},
    '{ACT_PUSH_REAR,  32'hFFFF_FFFF, 1'b1, ST_DONE},
    '{ACT_PUSH_FRONT, 32'h5555_5555, 1'b0, ST_DONE},
    '{ACT_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, ST_DONE},
    '{ACT_PUSH_FRONT, 32'h0000_0000, 1'b0, ST_DONE},
    '{ACT_PUSH_REAR,  32'h8000_0000, 1'b0, ST_DONE},
    '{ACT_PUSH_REAR,  32'h7FFF_FFFF, 1'b0, ST_DONE},
    '{ACT_PUSH_REAR,  32'h1234_5678, 1'b0, ST_DONE},
    '{ACT_PUSH_REAR,  32'h0F0F_0F0F, 1'b0, ST_DONE},
    '{ACT_PUSH_REAR,  32'hF0F0_F0F0, 1'b1, ST_OVERFLOW},
    '{ACT_PUSH_FRONT, 32'h0000_0001, 1'b1, ST_OVERFLOW},
    '{ACT_LIST,       32'h0000_0000, 1'b0, ST_DONE},
    '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, ST_DONE},
    '{ACT_POP_REAR,   32'h0000_0000, 1'b1, ST_DONE},
    '{ACT_LIST,       32'h0000_0000, 1'b0, ST_DONE},
    '{ACT_UNUSED_HI,  32'h0000_0000, 1'b0, ST_DONE},
    '{ACT_PUSH_FRONT, 32'hC001_D00D, 1'b0, ST_DONE}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACTION_W-1:0] in_action = ACT_PUSH_REAR;
  logic signed [VALUE_W-1:0] in_push_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic signed [VALUE_W-1:0] out_entry_value;
  logic out_last;

  circular_deque_ring #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_push_value(in_push_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_entry_value(out_entry_value),
    .out_last(out_last)
  );

  // deque mirror
  logic signed [VALUE_W-1:0] deque_words [DEPTH];
  logic [IDX_W-1:0] front_pos = '0;
  logic [IDX_W-1:0] rear_pos = '0;
  bit deque_empty = 1'b1;

  ring_result_t pending_results [$];
  ring_result_t oldest_pending;
  int error_count = 0;
  int items_accepted = 0;
  bit hold_active = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [IDX_W-1:0] pos_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] pos_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic int deque_fill();
    if (deque_empty) return 0;
    return ((int'(rear_pos) + DEPTH - int'(front_pos)) % DEPTH) + 1;
  endfunction

  task automatic expect_result(input status_t st, input logic signed [VALUE_W-1:0] v,
                               input logic lst);
    pending_results.push_back('{st, v, lst});
  endtask

  task automatic apply_action(input logic [ACTION_W-1:0] act,
                              input logic signed [VALUE_W-1:0] val);
    int fill;
    logic [IDX_W-1:0] idx;
    fill = deque_fill();
    case (act)
      ACT_PUSH_REAR, ACT_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          expect_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          if (deque_empty) begin
            front_pos = '0;
            rear_pos = '0;
            deque_empty = 1'b0;
            deque_words[0] = val;
          end else if (act == ACT_PUSH_REAR) begin
            rear_pos = pos_next(rear_pos);
            deque_words[rear_pos] = val;
          end else begin
            front_pos = pos_prev(front_pos);
            deque_words[front_pos] = val;
          end
          expect_result(ST_DONE, '0, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (deque_empty) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (front_pos == rear_pos) begin
            deque_empty = 1'b1;
            front_pos = '0;
            rear_pos = '0;
          end else if (act == ACT_POP_FRONT) begin
            front_pos = pos_next(front_pos);
          end else begin
            rear_pos = pos_prev(rear_pos);
          end
          expect_result(ST_DONE, '0, 1'b1);
        end
      end
      ACT_LIST: begin
        if (fill == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          idx = front_pos;
          for (int k = 0; k < fill; k++) begin
            expect_result(ST_DONE, deque_words[idx], k == fill - 1);
            idx = pos_next(idx);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (hold_active || (items_accepted % 64) < 12) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'sh7FFF_FFFF;
    if (r < 20) return 32'sh8000_0000;
    if (r < 25) return '0;
    if (r < 30) return '1;
    return $urandom;
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] act,
                           input logic signed [VALUE_W-1:0] val,
                           input logic typed, input status_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_push_value <= val;
    do @(posedge clk); while (in_stall);
    items_accepted++;
    apply_action(act, val);
    if (typed) begin
      void'(pending_results.pop_back());
      expect_result(want, '0, 1'b1);
    end
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  initial begin : stimulus
    int counted;
    int push_pct;
    int r;
    logic [ACTION_W-1:0] act;
    counted = 0;
    push_pct = 50;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].value,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end
    while (counted < N_RANDOM) begin
      if (counted % 25 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
        act = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end else begin
        counted++;
        if (r < 20) act = ACT_LIST;
        else if ($urandom_range(0, 99) < push_pct)
          act = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
        else
          act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
      end
      send_item(act, pick_value(), 1'b0, ST_DONE);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off to back the ring up
  initial begin : result_stall
    int r;
    int len;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && items_accepted >= HOLD_AT) begin
        held = 1'b1;
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 6);
        end else if (r < 85) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          len = $urandom_range(4, 15);
        end else begin
          out_stall <= 1'b0;
          len = $urandom_range(20, 40);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result status %0d entry %0d last %0d",
                               out_status, out_entry_value, out_last));
      end else begin
        oldest_pending = pending_results.pop_front();
        if (out_status !== oldest_pending.status
            || out_entry_value !== oldest_pending.entry
            || out_last !== oldest_pending.last) begin
          report_error($sformatf(
            "status exp %0d got %0d, entry exp %0d got %0d, last exp %0d got %0d",
            oldest_pending.status, out_status, oldest_pending.entry, out_entry_value,
            oldest_pending.last, out_last));
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
